// ===== hdl/gfsp_pkg.sv =====
// Shared types and constants of the genotype field stream parser.
// Depends on nothing; every other file of the block imports it.
package gfsp_pkg;

   localparam int TEXT_W      = 8;
   localparam int ALLELE_W    = 2;
   localparam int SAMPLE_W    = 16;
   localparam int GT_INDEX_W  = 4;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_GT_FIELD_INDEX = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT   = 1'b1;

   localparam logic [SAMPLE_W-1:0] SAMPLE_COUNT_RESET = 16'd1;

   localparam logic [ALLELE_W-1:0] ALLELE_MISSING = 2'd2;

   // One input item
   typedef struct packed {
      logic [TEXT_W-1:0] text_byte;
      logic              line_end;
   } item_type;

   // Registered input item with its valid flag
   typedef struct packed {
      logic     valid;
      item_type item;
   } stage_type;

   // One result item
   typedef struct packed {
      logic                genotype_valid;
      logic [ALLELE_W-1:0] first_allele;
      logic [ALLELE_W-1:0] second_allele;
      logic [SAMPLE_W-1:0] sample_number;
      logic                last_of_line;
      logic                count_error;
   } result_type;

endpackage

// ===== hdl/gfsp_req_if.sv =====
// Input channel of the genotype field stream parser: one text byte per item.
// Depends on gfsp_pkg for the field widths.
interface gfsp_req_if import gfsp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TEXT_W-1:0] text_byte;
   logic              line_end;

   modport source (output valid, output text_byte, output line_end, input ready);
   modport sink   (input valid, input text_byte, input line_end, output ready);
endinterface

// ===== hdl/gfsp_rsp_if.sv =====
// Result channel of the genotype field stream parser: one result per item, a genotype or a line close.
// Depends on gfsp_pkg for the field widths.
interface gfsp_rsp_if import gfsp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                genotype_valid;
   logic [ALLELE_W-1:0] first_allele;
   logic [ALLELE_W-1:0] second_allele;
   logic [SAMPLE_W-1:0] sample_number;
   logic                last_of_line;
   logic                count_error;

   modport source (output valid, output genotype_valid, output first_allele,
                   output second_allele, output sample_number, output last_of_line,
                   output count_error, input ready);
   modport sink   (input valid, input genotype_valid, input first_allele,
                   input second_allele, input sample_number, input last_of_line,
                   input count_error, output ready);
endinterface

// ===== hdl/gfsp_csr_if.sv =====
// Configuration write channel of the genotype field stream parser.
// Depends on gfsp_pkg for the index and data widths.
interface gfsp_csr_if import gfsp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== hdl/gfsp_in_stage.sv =====
// Input register of the genotype field stream parser.
// Depends on gfsp_pkg and gfsp_req_if.
module gfsp_in_stage import gfsp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   gfsp_req_if.sink  req_ch,
   input  logic      advance,
   output stage_type stage
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;

   assign req_ch.ready = !valid_ff || advance;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in          = 1'b1;
         item_in.text_byte = req_ch.text_byte;
         item_in.line_end  = req_ch.line_end;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

// ===== hdl/gfsp_core.sv =====
// Parser state, configuration registers and result logic of one text byte.
// Depends on gfsp_pkg and gfsp_csr_if.
module gfsp_core import gfsp_pkg::*; #(
   parameter int MAX_SAMPLES   = 65536,
   parameter int MAX_SUBFIELDS = 16
) (
   input  logic       clock,
   input  logic       reset,
   gfsp_csr_if.sink   csr_ch,
   input  stage_type  stage,
   input  logic       take,
   output logic       res_valid,
   output result_type result
);

   localparam int SUB_W = $clog2(MAX_SUBFIELDS + 1);
   localparam int SW    = (SUB_W > GT_INDEX_W) ? SUB_W : GT_INDEX_W;
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int CW    = (CNT_W > SAMPLE_W) ? CNT_W : SAMPLE_W;

   localparam logic [TEXT_W-1:0] CH_SPACE = 8'h20;
   localparam logic [TEXT_W-1:0] CH_TAB   = 8'h09;
   localparam logic [TEXT_W-1:0] CH_COLON = 8'h3A;
   localparam logic [TEXT_W-1:0] CH_PIPE  = 8'h7C;
   localparam logic [TEXT_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [TEXT_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [TEXT_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [TEXT_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [TEXT_W-1:0] CH_ONE   = 8'h31;
   localparam logic [TEXT_W-1:0] CH_NINE  = 8'h39;
   localparam logic [TEXT_W-1:0] CH_LF    = 8'h0A;
   localparam logic [TEXT_W-1:0] CH_CR    = 8'h0D;

   localparam logic [1:0] MAG_ZERO = 2'd0;
   localparam logic [1:0] MAG_ONE  = 2'd1;
   localparam logic [1:0] MAG_BIG  = 2'd2;
   localparam logic [1:0] CODE_REF = 2'd0;
   localparam logic [1:0] CODE_ALT = 2'd1;
   localparam logic [1:0] CODE_BAD = 2'd3;

   typedef enum logic [2:0] {
      PH_WAIT1, PH_SIGN1, PH_DIG1, PH_WAIT2, PH_SIGN2, PH_DIG2, PH_DONE, PH_FAIL
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [1:0] first_class;
      logic [1:0] second_class;
      logic       negative;
   } parse_type;

   localparam parse_type PARSE_IDLE = '{PH_WAIT1, MAG_ZERO, MAG_ZERO, 1'b0};

   function automatic logic [1:0] next_mag(input logic [1:0] mag,
                                           input logic [TEXT_W-1:0] c);
      logic [1:0] r;
      r = MAG_BIG;
      if (mag == MAG_ZERO && c == CH_ZERO) r = MAG_ZERO;
      if (mag == MAG_ZERO && c == CH_ONE)  r = MAG_ONE;
      return r;
   endfunction

   function automatic logic [1:0] allele_code(input logic [1:0] mag, input logic neg);
      logic [1:0] r;
      r = CODE_BAD;
      if (mag == MAG_ZERO) r = CODE_REF;
      if (mag == MAG_ONE)  r = neg ? ALLELE_MISSING : CODE_ALT;
      return r;
   endfunction

   // Both alleles of a closed genotype subfield: missing unless both numbers parsed
   // to a kept value.
   function automatic logic [2*ALLELE_W-1:0] finish(input parse_type p);
      logic [1:0] a;
      logic [1:0] b;
      a = p.first_class;
      b = allele_code(p.second_class, p.negative);
      if (!(p.phase == PH_DIG2 || p.phase == PH_DONE) || a == CODE_BAD || b == CODE_BAD) begin
         a = ALLELE_MISSING;
         b = ALLELE_MISSING;
      end
      return {a, b};
   endfunction

   logic [GT_INDEX_W-1:0] gt_idx_ff, gt_idx_in;
   logic [SAMPLE_W-1:0]   smp_cnt_ff, smp_cnt_in;
   logic [SUB_W-1:0]      sub_ff, sub_in, sub_upd;
   logic [CNT_W-1:0]      cnt_ff, cnt_in, cnt_upd;
   parse_type             parse_ff, parse_in, fed, post;

   logic [TEXT_W-1:0]     c;
   logic                  fire, delim, colon, digit, space, sign;
   logic                  gt_ok, in_gt_pre, in_gt_post;
   logic                  emit_early, emit_late, emit_any;
   logic [2*ALLELE_W-1:0] alleles;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      gt_idx_in  = gt_idx_ff;
      smp_cnt_in = smp_cnt_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.reg_index)
            CSR_GT_FIELD_INDEX: gt_idx_in  = csr_ch.wr_data[GT_INDEX_W-1:0];
            CSR_SAMPLE_COUNT:   smp_cnt_in = csr_ch.wr_data[SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

   assign c     = stage.item.text_byte;
   assign fire  = stage.valid && take;
   assign delim = (c == CH_SPACE) || (c == CH_TAB);
   assign colon = (c == CH_COLON);
   assign digit = (c >= CH_ZERO) && (c <= CH_NINE);
   assign space = (c >= CH_LF) && (c <= CH_CR);
   assign sign  = (c == CH_PLUS) || (c == CH_MINUS);
   assign gt_ok = 32'(gt_idx_ff) < MAX_SUBFIELDS;

   assign in_gt_pre = gt_ok && (SW'(sub_ff) == SW'(gt_idx_ff));

   // Advance the number parser by one byte of the genotype subfield
   always_comb begin
      fed = parse_ff;
      unique case (parse_ff.phase)
         PH_WAIT1, PH_WAIT2, PH_SIGN1, PH_SIGN2: begin
            if ((parse_ff.phase == PH_WAIT1 || parse_ff.phase == PH_WAIT2) && space) begin
               fed = parse_ff;
            end else if ((parse_ff.phase == PH_WAIT1 || parse_ff.phase == PH_WAIT2)
                         && sign) begin
               fed.negative = (c == CH_MINUS);
               fed.phase    = (parse_ff.phase == PH_WAIT1) ? PH_SIGN1 : PH_SIGN2;
            end else if (!digit) begin
               fed.phase = PH_FAIL;
            end else if (parse_ff.phase == PH_WAIT1 || parse_ff.phase == PH_SIGN1) begin
               fed.first_class = next_mag(MAG_ZERO, c);
               fed.phase       = PH_DIG1;
            end else begin
               fed.second_class = next_mag(MAG_ZERO, c);
               fed.phase        = PH_DIG2;
            end
         end
         PH_DIG1: begin
            if (digit) begin
               fed.first_class = next_mag(parse_ff.first_class, c);
            end else if (c == CH_PIPE || c == CH_SLASH) begin
               fed.first_class = allele_code(parse_ff.first_class, parse_ff.negative);
               fed.negative    = 1'b0;
               fed.phase       = PH_WAIT2;
            end else begin
               fed.phase = PH_FAIL;
            end
         end
         PH_DIG2: begin
            if (digit) begin
               fed.second_class = next_mag(parse_ff.second_class, c);
            end else begin
               fed.phase = PH_DONE;
            end
         end
         PH_DONE, PH_FAIL: fed = parse_ff;
         default: fed = parse_ff;
      endcase
   end

   always_comb begin
      sub_upd = sub_ff;
      post    = parse_ff;
      if (delim) begin
         sub_upd = '0;
         post    = PARSE_IDLE;
      end else if (colon) begin
         if (sub_ff < SUB_W'(MAX_SUBFIELDS)) sub_upd = sub_ff + SUB_W'(1);
         post = PARSE_IDLE;
      end else if (in_gt_pre) begin
         post = fed;
      end
   end

   assign in_gt_post = gt_ok && (SW'(sub_upd) == SW'(gt_idx_ff));
   assign emit_early = (delim || colon) && in_gt_pre;
   // A line closed inside the genotype subfield gives the genotype parsed so far
   assign emit_late  = stage.item.line_end && !delim && !emit_early && in_gt_post;
   assign emit_any   = emit_early || emit_late;
   assign alleles    = emit_early ? finish(parse_ff) : finish(post);

   always_comb begin
      cnt_upd = cnt_ff;
      if (emit_any && cnt_ff < CNT_W'(MAX_SAMPLES)) cnt_upd = cnt_ff + CNT_W'(1);
   end

   always_comb begin
      result.genotype_valid = emit_any;
      result.first_allele   = emit_any ? alleles[2*ALLELE_W-1:ALLELE_W] : ALLELE_MISSING;
      result.second_allele  = emit_any ? alleles[ALLELE_W-1:0] : ALLELE_MISSING;
      result.sample_number  = emit_any ? SAMPLE_W'(CW'(cnt_ff)) : '0;
      result.last_of_line   = stage.item.line_end;
      result.count_error    = stage.item.line_end && (CW'(cnt_upd) != CW'(smp_cnt_ff));
   end

   assign res_valid = emit_any || stage.item.line_end;

   always_comb begin
      sub_in   = sub_ff;
      cnt_in   = cnt_ff;
      parse_in = parse_ff;
      if (fire) begin
         if (stage.item.line_end) begin
            sub_in   = '0;
            cnt_in   = '0;
            parse_in = PARSE_IDLE;
         end else begin
            sub_in   = sub_upd;
            cnt_in   = cnt_upd;
            parse_in = post;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gt_idx_ff  <= '0;
         smp_cnt_ff <= SAMPLE_COUNT_RESET;
         sub_ff     <= '0;
         cnt_ff     <= '0;
         parse_ff   <= PARSE_IDLE;
      end else begin
         gt_idx_ff  <= gt_idx_in;
         smp_cnt_ff <= smp_cnt_in;
         sub_ff     <= sub_in;
         cnt_ff     <= cnt_in;
         parse_ff   <= parse_in;
      end
   end

endmodule

// ===== hdl/gfsp_out_stage.sv =====
// Result register of the genotype field stream parser.
// Depends on gfsp_pkg and gfsp_rsp_if.
module gfsp_out_stage import gfsp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result,
   output logic       free,
   gfsp_rsp_if.source rsp_ch
);

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // The slot can take a new result when empty or being drained this cycle
   assign free = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (free) begin
         valid_in = load;
         data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_ch.valid          = valid_ff;
   assign rsp_ch.genotype_valid = data_ff.genotype_valid;
   assign rsp_ch.first_allele   = data_ff.first_allele;
   assign rsp_ch.second_allele  = data_ff.second_allele;
   assign rsp_ch.sample_number  = data_ff.sample_number;
   assign rsp_ch.last_of_line   = data_ff.last_of_line;
   assign rsp_ch.count_error    = data_ff.count_error;

endmodule

// ===== hdl/genotype_field_stream_parser.sv =====
// Genotype field stream parser: reads the sample columns of a variant line one
// byte per item on req_ch and gives one genotype on rsp_ch for every sample
// token that reaches the configured colon-separated subfield, plus one closing
// result on the byte flagged line_end (last_of_line, count_error).
// csr_ch writes gt_field_index (index 0) and sample_count (index 1); it is
// always ready; the user must write it only while no line is in flight, as the
// block itself does not enforce this. A byte accepted into the input register
// has its result, if it gives one, loaded into the result register once that
// register is free, and the result is then offered on rsp_ch.
// Throughput: one byte per cycle while rsp_ch does not stall; the parser
// update between the two registers is combinational.
// When rsp_ch stalls, the result register holds and the input register keeps
// one more byte; req_ch.ready drops only when both are full.
// Reset (synchronous, active high) empties both registers, clears the parse
// state and the genotype count, and sets gt_field_index to 0 and
// sample_count to 1.
// Depends on gfsp_pkg, the three channel interfaces, gfsp_in_stage,
// gfsp_core and gfsp_out_stage.
module genotype_field_stream_parser import gfsp_pkg::*; #(
   parameter int MAX_SAMPLES   = 65536,
   parameter int MAX_SUBFIELDS = 16
) (
   input  logic       clock,
   input  logic       reset,
   gfsp_req_if.sink   req_ch,
   gfsp_rsp_if.source rsp_ch,
   gfsp_csr_if.sink   csr_ch
);

   stage_type  stage;
   result_type result;
   logic       res_valid;
   logic       free;

   gfsp_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .advance (free),
      .stage   (stage)
   );

   gfsp_core #(
      .MAX_SAMPLES   (MAX_SAMPLES),
      .MAX_SUBFIELDS (MAX_SUBFIELDS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_ch    (csr_ch),
      .stage     (stage),
      .take      (free),
      .res_valid (res_valid),
      .result    (result)
   );

   gfsp_out_stage u_out_stage (
      .clock  (clock),
      .reset  (reset),
      .load   (stage.valid && res_valid),
      .result (result),
      .free   (free),
      .rsp_ch (rsp_ch)
   );

endmodule

// ===== sim/gfsp_genotype_compare.sv =====
// Predicts every result of the genotype field stream parser from the accepted text
// bytes and register writes, and compares results in order, field by field.
// Depends on gfsp_pkg and the req, rsp and csr channel interfaces.
module gfsp_genotype_compare import gfsp_pkg::*; #(
   parameter int MAX_SAMPLES   = 65536,
   parameter int MAX_SUBFIELDS = 16
) (
   input  logic clock,
   input  logic reset,
   gfsp_req_if  req_ch,
   gfsp_rsp_if  rsp_ch,
   gfsp_csr_if  csr_ch,
   output int   mismatches,
   output int   genotypes_pending,
   output int   results_checked,
   output int   lines_closed
);

   typedef enum logic [2:0] {
      WAIT_FIRST,
      SIGN_FIRST,
      DIGITS_FIRST,
      WAIT_SECOND,
      SIGN_SECOND,
      DIGITS_SECOND,
      GT_DONE,
      GT_FAILED
   } number_phase_type;

   localparam logic [1:0] MAG_ZERO = 2'd0;
   localparam logic [1:0] MAG_ONE  = 2'd1;
   localparam logic [1:0] MAG_BIG  = 2'd2;

   localparam logic [ALLELE_W-1:0] ALLELE_REF = 2'd0;
   localparam logic [ALLELE_W-1:0] ALLELE_ALT = 2'd1;
   localparam logic [ALLELE_W-1:0] ALLELE_BAD = 2'd3;

   localparam logic [TEXT_W-1:0] CH_SPACE = " ";
   localparam logic [TEXT_W-1:0] CH_TAB   = 8'd9;
   localparam logic [TEXT_W-1:0] CH_COLON = ":";
   localparam logic [TEXT_W-1:0] CH_PIPE  = "|";
   localparam logic [TEXT_W-1:0] CH_SLASH = "/";
   localparam logic [TEXT_W-1:0] CH_PLUS  = "+";
   localparam logic [TEXT_W-1:0] CH_MINUS = "-";
   localparam logic [TEXT_W-1:0] CH_ZERO  = "0";
   localparam logic [TEXT_W-1:0] CH_ONE   = "1";
   localparam logic [TEXT_W-1:0] CH_NINE  = "9";

   localparam result_type NO_GENOTYPE = '{
      genotype_valid: 1'b0,
      first_allele:   ALLELE_MISSING,
      second_allele:  ALLELE_MISSING,
      sample_number:  '0,
      last_of_line:   1'b0,
      count_error:    1'b0
   };

   logic [GT_INDEX_W-1:0] gt_index;
   logic [SAMPLE_W-1:0]   expected_count;
   int unsigned           subfield_pos;
   number_phase_type      number_phase;
   logic [1:0]            first_class;
   logic [1:0]            second_class;
   logic                  negative;
   int unsigned           genotypes_on_line;
   result_type            expected_genotypes[$];

   function automatic logic [1:0] grow_class(input logic [1:0] cls, input logic [TEXT_W-1:0] c);
      if (cls == MAG_ZERO && c == CH_ZERO) return MAG_ZERO;
      if (cls == MAG_ZERO && c == CH_ONE) return MAG_ONE;
      return MAG_BIG;
   endfunction

   function automatic logic [ALLELE_W-1:0] to_allele(input logic [1:0] cls, input logic neg);
      if (cls == MAG_ZERO) return ALLELE_REF;
      if (cls == MAG_ONE) return neg ? ALLELE_MISSING : ALLELE_ALT;
      return ALLELE_BAD;
   endfunction

   function automatic logic in_genotype_field();
      return gt_index < MAX_SUBFIELDS && subfield_pos == gt_index;
   endfunction

   function automatic void clear_number();
      number_phase = WAIT_FIRST;
      first_class  = MAG_ZERO;
      second_class = MAG_ZERO;
      negative     = 1'b0;
   endfunction

   function automatic void feed_number(input logic [TEXT_W-1:0] c);
      logic is_digit;
      logic is_space;
      logic is_sign;
      logic opening;
      is_digit = c >= CH_ZERO && c <= CH_NINE;
      is_space = c >= 8'd10 && c <= 8'd13;
      is_sign  = c == CH_PLUS || c == CH_MINUS;
      opening  = number_phase == WAIT_FIRST || number_phase == WAIT_SECOND;
      case (number_phase)
         WAIT_FIRST, SIGN_FIRST, WAIT_SECOND, SIGN_SECOND: begin
            if (opening && is_sign) begin
               negative     = c == CH_MINUS;
               number_phase = number_phase == WAIT_FIRST ? SIGN_FIRST : SIGN_SECOND;
            end else if (!(opening && is_space)) begin
               if (!is_digit) begin
                  number_phase = GT_FAILED;
               end else if (number_phase == WAIT_FIRST || number_phase == SIGN_FIRST) begin
                  first_class  = grow_class(MAG_ZERO, c);
                  number_phase = DIGITS_FIRST;
               end else begin
                  second_class = grow_class(MAG_ZERO, c);
                  number_phase = DIGITS_SECOND;
               end
            end
         end
         DIGITS_FIRST: begin
            if (is_digit) begin
               first_class = grow_class(first_class, c);
            end else if (c == CH_PIPE || c == CH_SLASH) begin
               // keep the first allele code in place of its magnitude
               first_class  = to_allele(first_class, negative);
               negative     = 1'b0;
               number_phase = WAIT_SECOND;
            end else begin
               number_phase = GT_FAILED;
            end
         end
         DIGITS_SECOND: begin
            if (is_digit) second_class = grow_class(second_class, c);
            else number_phase = GT_DONE;
         end
         default: ;
      endcase
   endfunction

   function automatic result_type close_genotype();
      result_type r;
      r = NO_GENOTYPE;
      r.genotype_valid = 1'b1;
      if (number_phase == DIGITS_SECOND || number_phase == GT_DONE) begin
         r.first_allele  = first_class;
         r.second_allele = to_allele(second_class, negative);
         if (r.first_allele == ALLELE_BAD || r.second_allele == ALLELE_BAD) begin
            r.first_allele  = ALLELE_MISSING;
            r.second_allele = ALLELE_MISSING;
         end
      end
      r.sample_number = genotypes_on_line[SAMPLE_W-1:0];
      if (genotypes_on_line < MAX_SAMPLES) genotypes_on_line++;
      return r;
   endfunction

   task automatic predict_genotype(input logic [TEXT_W-1:0] c, input logic line_end);
      result_type r;
      logic       is_delim;
      logic       emitted;
      r        = NO_GENOTYPE;
      emitted  = 1'b0;
      is_delim = c == CH_SPACE || c == CH_TAB;
      if (is_delim || c == CH_COLON) begin
         if (in_genotype_field()) begin
            r       = close_genotype();
            emitted = 1'b1;
         end
         if (is_delim) subfield_pos = 0;
         else if (subfield_pos < MAX_SUBFIELDS) subfield_pos++;
         clear_number();
      end else if (in_genotype_field()) begin
         feed_number(c);
      end
      if (line_end) begin
         if (!is_delim && !emitted && in_genotype_field()) r = close_genotype();
         r.last_of_line    = 1'b1;
         r.count_error     = genotypes_on_line != expected_count;
         subfield_pos      = 0;
         genotypes_on_line = 0;
         clear_number();
      end
      if (emitted || line_end) expected_genotypes.push_back(r);
   endtask

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         gt_index          = '0;
         expected_count    = SAMPLE_COUNT_RESET;
         subfield_pos      = 0;
         genotypes_on_line = 0;
         clear_number();
         expected_genotypes.delete();
         mismatches        = 0;
         results_checked   = 0;
         lines_closed      = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.genotype_valid, rsp_ch.first_allele, rsp_ch.second_allele,
                    rsp_ch.sample_number, rsp_ch.last_of_line, rsp_ch.count_error};
            results_checked++;
            if (expected_genotypes.size() == 0) begin
               $error("result with no genotype expected: %p", got);
               mismatches++;
            end else begin
               want = expected_genotypes.pop_front();
               if (want.last_of_line) lines_closed++;
               check_field("genotype_valid", 32'(want.genotype_valid),
                           32'(got.genotype_valid));
               check_field("first_allele", 32'(want.first_allele), 32'(got.first_allele));
               check_field("second_allele", 32'(want.second_allele),
                           32'(got.second_allele));
               check_field("sample_number", 32'(want.sample_number),
                           32'(got.sample_number));
               check_field("last_of_line", 32'(want.last_of_line), 32'(got.last_of_line));
               check_field("count_error", 32'(want.count_error), 32'(got.count_error));
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.reg_index)
               CSR_GT_FIELD_INDEX: gt_index = csr_ch.wr_data[GT_INDEX_W-1:0];
               CSR_SAMPLE_COUNT:   expected_count = csr_ch.wr_data[SAMPLE_W-1:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) predict_genotype(req_ch.text_byte, req_ch.line_end);
      end
      genotypes_pending = expected_genotypes.size();
   end

endmodule

// ===== sim/genotype_field_stream_parser_tb.sv =====
// Top of the genotype field stream parser bench: clock, reset, text stimulus,
// register settings and the verdict. Depends on gfsp_pkg, the channel interfaces,
// genotype_field_stream_parser and gfsp_genotype_compare.
module genotype_field_stream_parser_tb import gfsp_pkg::*; ();

   localparam int LIMIT_CYCLES     = 400000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int PHASES           = 8;
   localparam int BYTES_PER_PHASE  = 110;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gfsp_req_if req_ch ();
   gfsp_rsp_if rsp_ch ();
   gfsp_csr_if csr_ch ();

   int mismatches;
   int genotypes_pending;
   int results_checked;
   int lines_closed;

   logic [TEXT_W-1:0] line_text[$];
   bit                calm = 1'b0;
   bit                hold_request = 1'b0;
   int                bytes_sent = 0;
   int                cycle_count = 0;

   genotype_field_stream_parser dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   gfsp_genotype_compare compare_unit (
      .clock             (clock),
      .reset             (reset),
      .req_ch            (req_ch),
      .rsp_ch            (rsp_ch),
      .csr_ch            (csr_ch),
      .mismatches        (mismatches),
      .genotypes_pending (genotypes_pending),
      .results_checked   (results_checked),
      .lines_closed      (lines_closed)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("timed out after %0d cycles", cycle_count);
         $display("genotype_field_stream_parser regression: fail");
         $finish;
      end
   end

   // result side: random stalls, one long hold on request, none once calm
   initial begin : rsp_drain
      int stall;
      rsp_ch.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES - 1) @(negedge clock);
            hold_request = 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 15);
            rsp_ch.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_byte(input logic [TEXT_W-1:0] c, input logic last);
      if (!calm && $urandom_range(0, 9) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.text_byte <= c;
      req_ch.line_end  <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_line();
      foreach (line_text[i]) send_byte(line_text[i], i == line_text.size() - 1);
   endtask

   // hold the input until every genotype is back and the block has gone quiet
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      wait (genotypes_pending == 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic apply_settings(input int gt, input int count);
      csr_ch.valid     <= 1'b1;
      csr_ch.reg_index <= CSR_GT_FIELD_INDEX;
      csr_ch.wr_data   <= CSR_DATA_W'(gt);
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
      csr_ch.reg_index <= CSR_SAMPLE_COUNT;
      csr_ch.wr_data   <= CSR_DATA_W'(count);
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic append_text(input string s);
      foreach (s[i]) line_text.push_back(s[i]);
   endtask

   task automatic put_filler();
      logic [TEXT_W-1:0] c;
      repeat ($urandom_range(0, 3)) begin
         c = TEXT_W'($urandom_range(33, 126));
         if (c == ":") c = ".";
         line_text.push_back(c);
      end
   endtask

   task automatic put_number();
      int sign_pick;
      int digits;
      if ($urandom_range(0, 7) == 0) line_text.push_back(TEXT_W'($urandom_range(10, 13)));
      sign_pick = $urandom_range(0, 5);
      if (sign_pick == 0) line_text.push_back("+");
      else if (sign_pick == 1) line_text.push_back("-");
      case ($urandom_range(0, 11))
         0:       digits = 0;
         1:       digits = $urandom_range(2, 3);
         default: digits = 1;
      endcase
      repeat (digits) begin
         if ($urandom_range(0, 3) == 0) line_text.push_back(TEXT_W'("0" + $urandom_range(0, 9)));
         else line_text.push_back(TEXT_W'("0" + $urandom_range(0, 1)));
      end
   endtask

   task automatic put_genotype();
      case ($urandom_range(0, 9))
         0: append_text(".|.");
         1: ;
         default: begin
            put_number();
            if ($urandom_range(0, 9) == 0) put_filler();
            else if ($urandom_range(0, 1) == 0) line_text.push_back("|");
            else line_text.push_back("/");
            put_number();
            if ($urandom_range(0, 4) == 0) put_filler();
         end
      endcase
   endtask

   task automatic put_token(input int gt);
      int subfields;
      if ($urandom_range(0, 7) == 0) subfields = $urandom_range(0, 18);
      else subfields = gt + 1 + $urandom_range(0, 1);
      for (int f = 0; f < subfields; f++) begin
         if (f > 0) line_text.push_back(":");
         if (f == gt) put_genotype();
         else put_filler();
      end
   endtask

   // well-formed lines with random content; some noise lines and stray bytes
   task automatic compose_line(input int gt, input int expected);
      int tokens;
      int ending;
      line_text.delete();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 12)) line_text.push_back(TEXT_W'($urandom_range(0, 255)));
         return;
      end
      if (expected == 0 || expected > 8) tokens = $urandom_range(1, 4);
      else tokens = expected - 1 + $urandom_range(0, 2);
      if (tokens < 1) tokens = 1;
      for (int t = 0; t < tokens; t++) begin
         if (t > 0) begin
            line_text.push_back($urandom_range(0, 1) ? " " : "\t");
            if ($urandom_range(0, 9) == 0) line_text.push_back(" ");
         end
         put_token(gt);
      end
      ending = $urandom_range(0, 19);
      if (ending < 3) line_text.push_back("\t");
      else if (ending < 6) line_text.push_back(":");
      if (line_text.size() == 0) line_text.push_back(" ");
      foreach (line_text[i]) begin
         if ($urandom_range(0, 39) == 0) line_text[i] = TEXT_W'($urandom_range(0, 255));
      end
   endtask

   initial begin : stimulus
      int gt_sel;
      int count_sel;
      int start_bytes;
      req_ch.valid     = 1'b0;
      req_ch.text_byte = '0;
      req_ch.line_end  = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.reg_index = CSR_GT_FIELD_INDEX;
      csr_ch.wr_data   = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed lines under the reset settings: signs, missing and large values,
      // empty tokens, skipped whitespace, closing without a genotype, byte extremes
      line_text.delete();
      append_text("0|1 -1/+1\t\t2|0");
      send_line();
      line_text.delete();
      line_text.push_back(8'd10);
      append_text("1|");
      line_text.push_back(8'd13);
      append_text("0:");
      send_line();
      line_text.delete();
      append_text("0|0:");
      line_text.push_back(8'hFF);
      send_line();
      line_text.delete();
      line_text.push_back(8'h00);
      append_text(" ");
      send_line();
      drain_results();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin gt_sel = 0;  count_sel = 3;     end
            1: begin gt_sel = 15; count_sel = 0;     end
            2: begin gt_sel = 1;  count_sel = 65535; end
            3: begin gt_sel = 2;  count_sel = 2;     end
            default: begin
               gt_sel = $urandom_range(0, 5) == 0 ? $urandom_range(3, 15) : $urandom_range(0, 2);
               count_sel = $urandom_range(0, 5);
            end
         endcase
         calm = p == PHASES - 1;
         apply_settings(gt_sel, count_sel);
         if (p == 2) hold_request = 1'b1;
         start_bytes = bytes_sent;
         while (bytes_sent - start_bytes < BYTES_PER_PHASE) begin
            compose_line(gt_sel, count_sel);
            send_line();
         end
         drain_results();
      end
      repeat (8) @(negedge clock);

      $display("Covered %0d text bytes in %0d closed lines across %0d register settings,",
               bytes_sent, lines_closed, PHASES + 1);
      $display("with %0d results compared under random stalls and one long receiver hold.",
               results_checked);
      if (mismatches == 0 && genotypes_pending == 0) begin
         $display("genotype_field_stream_parser regression: pass");
      end else begin
         $display("genotype_field_stream_parser regression: fail");
      end
      $finish;
   end

endmodule
